@@ design/pjq_pkg.sv @@
// Shared types and constants for the two-level priority job queue.
// Used by the cell, the cell row and the top level; depends on nothing.
package pjq_pkg;

  // Default number of entries in each queue
  localparam int QUEUE_DEPTH = 128;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_CANCEL   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // One stored job
  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] page_count;
    logic [31:0] doc_handle;
  } entry_t;

  // What every cell of a row does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,  // keep the entry
    CELL_ROTATE = 2'd1,  // take the entry of the next cell in the ring
    CELL_SHIFT  = 2'd2,  // take the next entry if at or past the position
    CELL_LOAD   = 2'd3   // take the new entry if at the position
  } cell_op_t;

  // Row control that travels from the sequencer to a cell row
  typedef struct packed {
    cell_op_t op;
    entry_t   fresh;
  } row_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

endpackage

@@ design/pjq_req_if.sv @@
// Request channel of the job queue: valid/ready handshake and request payload.
// Depends on nothing.
interface pjq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] job_id;
  logic [15:0] page_count;
  logic [31:0] doc_handle;
  logic        urgent;

  modport source (output valid, operation, job_id, page_count, doc_handle, urgent,
                  input ready);
  modport sink   (input valid, operation, job_id, page_count, doc_handle, urgent,
                  output ready);
endinterface

@@ design/pjq_resp_if.sv @@
// Result channel of the job queue: valid/ready handshake and result payload.
// Depends on nothing.
interface pjq_resp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        from_priority;
  logic [15:0] out_job_id;
  logic [15:0] out_page_count;
  logic [31:0] out_doc_handle;

  modport source (output valid, status, from_priority, out_job_id, out_page_count,
                  out_doc_handle, input ready);
  modport sink   (input valid, status, from_priority, out_job_id, out_page_count,
                  out_doc_handle, output ready);
endinterface

@@ design/two_level_priority_job_queue.sv @@
// Top level of the two-level strict-priority job queue: sequencer, counts,
// result register and two cell rows. Depends on pjq_pkg, pjq_req_if,
// pjq_resp_if and pjq_row.
//
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   operation, job_id, page_count, doc_handle, urgent
//   resp     out  valid/ready   status, from_priority, out_job_id, out_page_count,
//                               out_doc_handle
//
// Dispatch goes from idle straight to the result; add, search and cancel first scan
// one full rotation of both cell rows past the compare at cell 0.
// Search and cancel on two empty queues skip the rotation.
// Reset clears the counts, the sequencer and the result valid; cell contents stay.
// A request is taken only in idle; a held result stalls the sequencer in its last
// cycle while the result register stays full.
module two_level_priority_job_queue #(
  parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  pjq_req_if.sink    req,
  pjq_resp_if.source resp
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_STEP = PTR_W'(QUEUE_DEPTH - 1);

  pjq_pkg::state_t state, state_next;

  // Latched request
  pjq_pkg::op_t req_op;
  pjq_pkg::entry_t req_ent;
  logic req_urg;

  // Scan state
  logic [PTR_W-1:0] scan_k;
  logic hit_u, hit_n;
  logic [PTR_W-1:0] off_u, off_n;
  pjq_pkg::entry_t ent_u, ent_n;

  // Queue occupancy
  logic [CNT_W-1:0] ucount, ucount_next;
  logic [CNT_W-1:0] ncount, ncount_next;

  // Result register
  logic res_valid;
  pjq_pkg::status_t res_status, res_status_next;
  logic res_fp, res_fp_next;
  pjq_pkg::entry_t res_ent, res_ent_next;
  logic res_load;

  // Row control
  pjq_pkg::row_ctrl_t u_ctrl, n_ctrl;
  logic [PTR_W-1:0] u_pos, n_pos;
  pjq_pkg::entry_t head_u, head_n;

  logic empty, slot_free, step_hit_u, step_hit_n;

  assign empty     = (ucount == '0) && (ncount == '0);
  assign slot_free = !res_valid || resp.ready;
  assign step_hit_u = !hit_u && (CNT_W'(scan_k) < ucount) && (head_u.job_id == req_ent.job_id);
  assign step_hit_n = !hit_n && (CNT_W'(scan_k) < ncount) && (head_n.job_id == req_ent.job_id);

  pjq_row #(.QUEUE_DEPTH(QUEUE_DEPTH), .POS_W(PTR_W)) u_urgent_row (
    .clk  (clk),
    .ctrl (u_ctrl),
    .pos  (u_pos),
    .head (head_u)
  );

  pjq_row #(.QUEUE_DEPTH(QUEUE_DEPTH), .POS_W(PTR_W)) u_normal_row (
    .clk  (clk),
    .ctrl (n_ctrl),
    .pos  (n_pos),
    .head (head_n)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pjq_pkg::S_IDLE: begin
        if (req.valid) begin
          if (pjq_pkg::op_t'(req.operation) == pjq_pkg::OP_ADD ||
              (pjq_pkg::op_t'(req.operation) != pjq_pkg::OP_DISPATCH && !empty)) begin
            state_next = pjq_pkg::S_SCAN;
          end else begin
            state_next = pjq_pkg::S_DONE;
          end
        end
      end
      pjq_pkg::S_SCAN: begin
        if (scan_k == LAST_STEP) state_next = pjq_pkg::S_DONE;
      end
      pjq_pkg::S_DONE: begin
        if (slot_free) state_next = pjq_pkg::S_IDLE;
      end
      default: state_next = pjq_pkg::S_IDLE;
    endcase
  end

  // Outputs: row control, count updates and result
  always_comb begin
    req.ready       = (state == pjq_pkg::S_IDLE);
    u_ctrl.op       = pjq_pkg::CELL_HOLD;
    u_ctrl.fresh    = req_ent;
    n_ctrl.op       = pjq_pkg::CELL_HOLD;
    n_ctrl.fresh    = req_ent;
    u_pos           = '0;
    n_pos           = '0;
    ucount_next     = ucount;
    ncount_next     = ncount;
    res_load        = 1'b0;
    res_status_next = pjq_pkg::ST_OK;
    res_fp_next     = 1'b0;
    res_ent_next    = '0;

    if (state == pjq_pkg::S_SCAN) begin
      u_ctrl.op = pjq_pkg::CELL_ROTATE;
      n_ctrl.op = pjq_pkg::CELL_ROTATE;
    end else if (state == pjq_pkg::S_DONE && slot_free) begin
      res_load = 1'b1;
      unique case (req_op)
        pjq_pkg::OP_ADD: begin
          priority if (hit_n) begin
            res_status_next = pjq_pkg::ST_DUP;
            res_fp_next     = hit_u;
          end else if (hit_u) begin
            res_status_next = pjq_pkg::ST_DUP;
            res_fp_next     = 1'b1;
          end else if (req_urg ? (ucount == FULL_CNT) : (ncount == FULL_CNT)) begin
            res_status_next = pjq_pkg::ST_FULL;
            res_fp_next     = req_urg;
          end else begin
            res_fp_next = req_urg;
            if (req_urg) begin
              u_ctrl.op   = pjq_pkg::CELL_LOAD;
              u_pos       = ucount[PTR_W-1:0];
              ucount_next = ucount + CNT_W'(1);
            end else begin
              n_ctrl.op   = pjq_pkg::CELL_LOAD;
              n_pos       = ncount[PTR_W-1:0];
              ncount_next = ncount + CNT_W'(1);
            end
          end
        end
        pjq_pkg::OP_DISPATCH: begin
          priority if (empty) begin
            res_status_next = pjq_pkg::ST_EMPTY;
          end else if (ucount != '0) begin
            res_fp_next  = 1'b1;
            res_ent_next = head_u;
            u_ctrl.op    = pjq_pkg::CELL_SHIFT;
            ucount_next  = ucount - CNT_W'(1);
          end else begin
            res_ent_next = head_n;
            n_ctrl.op    = pjq_pkg::CELL_SHIFT;
            ncount_next  = ncount - CNT_W'(1);
          end
        end
        pjq_pkg::OP_SEARCH, pjq_pkg::OP_CANCEL: begin
          priority if (empty) begin
            res_status_next = pjq_pkg::ST_EMPTY;
          end else if (hit_u) begin
            res_fp_next  = 1'b1;
            res_ent_next = ent_u;
            if (req_op == pjq_pkg::OP_CANCEL) begin
              u_ctrl.op   = pjq_pkg::CELL_SHIFT;
              u_pos       = off_u;
              ucount_next = ucount - CNT_W'(1);
            end
          end else if (hit_n) begin
            res_ent_next = ent_n;
            if (req_op == pjq_pkg::OP_CANCEL) begin
              n_ctrl.op   = pjq_pkg::CELL_SHIFT;
              n_pos       = off_n;
              ncount_next = ncount - CNT_W'(1);
            end
          end else begin
            res_status_next = pjq_pkg::ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pjq_pkg::S_IDLE;
      ucount    <= '0;
      ncount    <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      ucount <= ucount_next;
      ncount <= ncount_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (resp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Latch request, track scan hits, load result
  always_ff @(posedge clk) begin
    if (state == pjq_pkg::S_IDLE && req.valid) begin
      req_op             <= pjq_pkg::op_t'(req.operation);
      req_ent.job_id     <= req.job_id;
      req_ent.page_count <= req.page_count;
      req_ent.doc_handle <= req.doc_handle;
      req_urg            <= req.urgent;
      scan_k             <= '0;
      hit_u              <= 1'b0;
      hit_n              <= 1'b0;
    end
    if (state == pjq_pkg::S_SCAN) begin
      scan_k <= scan_k + PTR_W'(1);
      if (step_hit_u) begin
        hit_u <= 1'b1;
        off_u <= scan_k;
        ent_u <= head_u;
      end
      if (step_hit_n) begin
        hit_n <= 1'b1;
        off_n <= scan_k;
        ent_n <= head_n;
      end
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_fp     <= res_fp_next;
      res_ent    <= res_ent_next;
    end
  end

  assign resp.valid          = res_valid;
  assign resp.status         = res_status;
  assign resp.from_priority  = res_fp;
  assign resp.out_job_id     = res_ent.job_id;
  assign resp.out_page_count = res_ent.page_count;
  assign resp.out_doc_handle = res_ent.doc_handle;

  // Occupancy never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ucount <= FULL_CNT) && (ncount <= FULL_CNT))
    else $error("queue count beyond depth");

  // Counts move only when a request finishes
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !(state == pjq_pkg::S_DONE && slot_free) |=> ($stable(ucount) && $stable(ncount)))
    else $error("queue count changed outside request completion");

  // A finishing request leaves a result behind
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == pjq_pkg::S_DONE && slot_free) |=> resp.valid)
    else $error("finished request produced no result");

  // Last rotation step ends the scan
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == pjq_pkg::S_SCAN && scan_k == LAST_STEP) |=> state == pjq_pkg::S_DONE)
    else $error("scan ran past one full rotation");

  // Urgent count grows by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (ucount > $past(ucount)) |-> (ucount == $past(ucount) + CNT_W'(1)))
    else $error("urgent count jumped");

endmodule

@@ design/pjq_cell.sv @@
// One queue cell: holds a single job and moves it per the row control.
// Depends on pjq_pkg.
module pjq_cell #(
  parameter int POS_W = 7,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  pjq_pkg::row_ctrl_t ctrl,
  input  logic [POS_W-1:0]   pos,
  input  pjq_pkg::entry_t    nxt,
  output pjq_pkg::entry_t    ent
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  // Update the held entry
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      pjq_pkg::CELL_HOLD: begin
      end
      pjq_pkg::CELL_ROTATE: begin
        ent <= nxt;
      end
      pjq_pkg::CELL_SHIFT: begin
        if (IDX >= pos) ent <= nxt;
      end
      pjq_pkg::CELL_LOAD: begin
        if (IDX == pos) ent <= ctrl.fresh;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/pjq_row.sv @@
// Row of queue cells linked in a ring; cell 0 holds the queue head.
// Depends on pjq_pkg and pjq_cell.
module pjq_row #(
  parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH,
  parameter int POS_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  pjq_pkg::row_ctrl_t ctrl,
  input  logic [POS_W-1:0]   pos,
  output pjq_pkg::entry_t    head
);

  pjq_pkg::entry_t ents [QUEUE_DEPTH];

  // Chain the cells, last one wrapping to cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % QUEUE_DEPTH;
    pjq_cell #(
      .POS_W (POS_W),
      .INDEX (i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .pos  (pos),
      .nxt  (ents[NXT]),
      .ent  (ents[i])
    );
  end

  assign head = ents[0];

endmodule
